// ===== rtl/assert_macros.svh =====
// assertion macros shared by the spline evaluator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CRS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: check failed");

// condition that forces a consequence at the next clock edge
`define CRS_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("%m: check failed");

`endif

// ===== rtl/crs_pkg.sv =====
// package with shared constants and helpers for the spline segment evaluator
package crs_pkg;

    // default coordinate width and fraction bits
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // extra bits of a basis weight above the fraction (sign plus headroom)
    localparam int BASIS_EXTRA = 3;

    // number of register stages from input transfer to output register
    localparam int PIPE_DEPTH = 6;

    // round a bit count up to whole bytes
    function automatic int byte_round(input int bits);
        return ((bits + 7) >> 3) << 3;
    endfunction

endpackage

// ===== rtl/crs_basis.sv =====
// three-stage hermite basis generator from the interpolation parameter
module crs_basis #(
    parameter int FB = crs_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_ce,
    input  logic [FB:0]                            i_t,
    output logic signed [FB+crs_pkg::BASIS_EXTRA-1:0] o_h00,
    output logic signed [FB+crs_pkg::BASIS_EXTRA-1:0] o_h10,
    output logic signed [FB+crs_pkg::BASIS_EXTRA-1:0] o_h01,
    output logic signed [FB+crs_pkg::BASIS_EXTRA-1:0] o_h11
);
    import crs_pkg::*;
    `include "assert_macros.svh"

    localparam int HW = FB + BASIS_EXTRA;
    localparam logic [FB:0] ONE_T = {1'b1, {FB{1'b0}}};
    localparam logic signed [HW-1:0] ONE_H = HW'(ONE_T);

    logic [FB:0]        n_tc;
    logic [2*FB+1:0]    n_sq;
    logic [2*FB+1:0]    n_cube;
    logic [FB:0]        r_t1, r_t2a;
    logic [FB:0]        r_t2b, r_t3, r_tb;
    logic signed [HW-1:0] w_t, w_t2, w_t3;
    logic signed [HW-1:0] r_h00, r_h10, r_h01, r_h11;

    // stage 1: clamp t to one, square it
    always_comb begin
        n_tc = (i_t > ONE_T) ? ONE_T : i_t;
        n_sq = (2*FB+2)'(n_tc) * (2*FB+2)'(n_tc);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_t1  <= n_tc;
            r_t2a <= n_sq[FB +: FB+1];
        end
    end

    // stage 2: cube from the truncated square
    assign n_cube = (2*FB+2)'(r_t2a) * (2*FB+2)'(r_t1);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_tb  <= r_t1;
            r_t2b <= r_t2a;
            r_t3  <= n_cube[FB +: FB+1];
        end
    end

    // stage 3: basis weights by adds only
    assign w_t  = $signed({2'b00, r_tb});
    assign w_t2 = $signed({2'b00, r_t2b});
    assign w_t3 = $signed({2'b00, r_t3});

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_h00 <= (w_t3 <<< 1) - (w_t2 + (w_t2 <<< 1)) + ONE_H;
            r_h10 <= (w_t2 + (w_t2 <<< 1)) - (w_t3 <<< 1);
            r_h01 <= w_t3 - (w_t2 <<< 1) + w_t;
            r_h11 <= w_t3 - w_t2;
        end
    end

    assign o_h00 = r_h00;
    assign o_h10 = r_h10;
    assign o_h01 = r_h01;
    assign o_h11 = r_h11;

    // the two end weights always add up to one
    `CRS_ASSERT(a_end_weights_sum, $past(i_ce, 3) |-> (HW'(r_h00 + r_h10) == ONE_H) || !$past(i_rst_n, 3))

endmodule

// ===== rtl/crs_term.sv =====
// two-stage coordinate by weight product with truncating shift
module crs_term #(
    parameter int CW = crs_pkg::COORD_WIDTH_DEF,
    parameter int FB = crs_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_ce,
    input  logic signed [CW-1:0]                      i_coord,
    input  logic signed [FB+crs_pkg::BASIS_EXTRA-1:0] i_weight,
    output logic signed [CW+crs_pkg::BASIS_EXTRA-1:0] o_term
);
    import crs_pkg::*;

    localparam int HW = FB + BASIS_EXTRA;
    localparam int LW = CW / 2;
    localparam int UW = CW - LW;
    localparam int FW = CW + HW;

    logic signed [LW+HW:0]   r_plo;
    logic signed [UW+HW-1:0] r_phi;
    logic signed [FW-1:0]    w_full;
    logic signed [CW+BASIS_EXTRA-1:0] r_term;

    // stage 1: split the coordinate into two narrower partial products
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_plo <= (LW+HW+1)'($signed({1'b0, i_coord[LW-1:0]})) * (LW+HW+1)'(i_weight);
            r_phi <= (UW+HW)'($signed(i_coord[CW-1:LW])) * (UW+HW)'(i_weight);
        end
    end

    // stage 2: recombine and floor by the fraction bits
    assign w_full = (FW'(r_phi) <<< LW) + FW'(r_plo);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_term <= $signed(w_full[FW-1:FB]);
        end
    end

    assign o_term = r_term;

endmodule

// ===== rtl/crs_sum.sv =====
// final adder of the four terms with saturation to the coordinate range
module crs_sum #(
    parameter int CW = crs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_ce,
    input  logic signed [CW+crs_pkg::BASIS_EXTRA-1:0] i_term0,
    input  logic signed [CW+crs_pkg::BASIS_EXTRA-1:0] i_term1,
    input  logic signed [CW+crs_pkg::BASIS_EXTRA-1:0] i_term2,
    input  logic signed [CW+crs_pkg::BASIS_EXTRA-1:0] i_term3,
    output logic signed [CW-1:0]                      o_value,
    output logic                                      o_sat
);
    import crs_pkg::*;

    localparam int SW = CW + BASIS_EXTRA + 2;
    localparam logic signed [CW-1:0] MAX_V = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN_V = {1'b1, {(CW-1){1'b0}}};

    logic signed [SW-1:0] n_sum;
    logic [SW-CW:0]       w_top;
    logic                 n_ovf;
    logic signed [CW-1:0] n_value;
    logic signed [CW-1:0] r_value;
    logic                 r_sat;

    // exact sum, then clip when the upper bits are not all sign
    always_comb begin
        n_sum   = SW'(i_term0) + SW'(i_term1) + SW'(i_term2) + SW'(i_term3);
        w_top   = n_sum[SW-1:CW-1];
        n_ovf   = !((&w_top) || !(|w_top));
        n_value = n_ovf ? (n_sum[SW-1] ? MIN_V : MAX_V) : n_sum[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_value <= n_value;
            r_sat   <= n_ovf;
        end
    end

    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule

// ===== rtl/catmull_rom_segment_eval_top.sv =====
// catmull-rom segment evaluator, one axis per transfer
// pipeline: six register stages between the input transfer and the output
// throughput: one item per cycle; the pipeline advances whenever the output
//   register is empty or being taken, so a stall freezes every stage
// reset: synchronous active-low i_rst_n clears the stage valid bits only
module catmull_rom_segment_eval_top #(
    parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = crs_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // point_before, point_start, point_end, point_after, param_t, zero pad
    input  logic [crs_pkg::byte_round(4*COORD_WIDTH+FRAC_BITS+1)-1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // curve_value, zero pad
    output logic [crs_pkg::byte_round(COORD_WIDTH)-1:0] m_axis_tdata,
    // saturated
    output logic [0:0] m_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready
);
    import crs_pkg::*;
    `include "assert_macros.svh"

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int HW    = FB + BASIS_EXTRA;
    localparam int TW    = CW + BASIS_EXTRA;
    localparam int OUT_W = byte_round(CW);

    typedef struct packed {
        logic signed [CW-1:0] p0;
        logic signed [CW-1:0] p1;
        logic signed [CW-1:0] m0;
        logic signed [CW-1:0] m1;
    } t_pts;

    logic                 w_ce;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic signed [CW-1:0] w_pb, w_p0, w_p1, w_pa;
    logic [FB:0]          w_t;
    logic signed [CW:0]   n_d0, n_d1;
    t_pts                 n_pts;
    t_pts                 r_pts [3];
    logic signed [HW-1:0] w_h00, w_h10, w_h01, w_h11;
    logic signed [TW-1:0] w_term0, w_term1, w_term2, w_term3;
    logic signed [CW-1:0] w_value;
    logic                 w_sat;

    // global advance: move when the output slot is free or being taken
    assign w_ce          = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_ce;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    // unpack the input transfer
    assign w_pb = $signed(s_axis_tdata[0*CW +: CW]);
    assign w_p0 = $signed(s_axis_tdata[1*CW +: CW]);
    assign w_p1 = $signed(s_axis_tdata[2*CW +: CW]);
    assign w_pa = $signed(s_axis_tdata[3*CW +: CW]);
    assign w_t  = s_axis_tdata[4*CW +: FB+1];

    // tangents: exact difference halved with floor
    always_comb begin
        n_d0     = (CW+1)'(w_p1) - (CW+1)'(w_pb);
        n_d1     = (CW+1)'(w_pa) - (CW+1)'(w_p0);
        n_pts.p0 = w_p0;
        n_pts.p1 = w_p1;
        n_pts.m0 = $signed(n_d0[CW:1]);
        n_pts.m1 = $signed(n_d1[CW:1]);
    end

    // coordinates wait alongside the basis stages
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_pts[0] <= n_pts;
            r_pts[1] <= r_pts[0];
            r_pts[2] <= r_pts[1];
        end
    end

    crs_basis #(.FB(FB)) u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_t     (w_t),
        .o_h00   (w_h00),
        .o_h10   (w_h10),
        .o_h01   (w_h01),
        .o_h11   (w_h11)
    );

    // four weighted terms
    crs_term #(.CW(CW), .FB(FB)) u_term0 (
        .i_clk (i_clk), .i_ce (w_ce), .i_coord (r_pts[2].p0), .i_weight (w_h00),
        .o_term (w_term0)
    );
    crs_term #(.CW(CW), .FB(FB)) u_term1 (
        .i_clk (i_clk), .i_ce (w_ce), .i_coord (r_pts[2].p1), .i_weight (w_h10),
        .o_term (w_term1)
    );
    crs_term #(.CW(CW), .FB(FB)) u_term2 (
        .i_clk (i_clk), .i_ce (w_ce), .i_coord (r_pts[2].m0), .i_weight (w_h01),
        .o_term (w_term2)
    );
    crs_term #(.CW(CW), .FB(FB)) u_term3 (
        .i_clk (i_clk), .i_ce (w_ce), .i_coord (r_pts[2].m1), .i_weight (w_h11),
        .o_term (w_term3)
    );

    crs_sum #(.CW(CW)) u_sum (
        .i_clk   (i_clk),
        .i_ce    (w_ce),
        .i_term0 (w_term0),
        .i_term1 (w_term1),
        .i_term2 (w_term2),
        .i_term3 (w_term3),
        .o_value (w_value),
        .o_sat   (w_sat)
    );

    // output transfer
    assign m_axis_tvalid   = r_vld[PIPE_DEPTH-1];
    assign m_axis_tdata    = OUT_W'($unsigned(w_value));
    assign m_axis_tuser[0] = w_sat;

    // a clipped result sits exactly on one of the range bounds
    `CRS_ASSERT(a_sat_at_bound, m_axis_tvalid && w_sat |-> w_value[CW-2:0] == {(CW-1){~w_value[CW-1]}})
    // a stalled pipeline keeps every valid bit
    `CRS_ASSERT_NEXT(a_stall_holds, !w_ce, $stable(r_vld))
    // output valid only rises from an item in the last term stage
    `CRS_ASSERT(a_valid_source, !$rose(m_axis_tvalid) || $past(r_vld[PIPE_DEPTH-2]))

endmodule
